// ===== rtl/gfr_pkg.sv =====
// ----------------------------------------------------------------------------
// gfr_pkg
// Shared types and constants of the 5x7 glyph rasterizer: font table,
// character range, cell geometry and configuration register indexes.
// ----------------------------------------------------------------------------
package gfr_pkg;

  localparam logic [7:0] CODE_FIRST = 8'h20;
  localparam logic [7:0] CODE_LAST  = 8'h7E;
  localparam logic [7:0] CODE_SUBST = 8'h3F;

  localparam int GLYPH_COUNT = 95;
  localparam int GLYPH_COLS  = 5;

  localparam logic [2:0] COL_LAST_GLYPH  = 3'd4;
  localparam logic [2:0] COL_LAST_SPACER = 3'd5;
  localparam logic [2:0] ROW_LAST        = 3'd6;

  localparam logic [2:0] REPEAT_NORMAL = 3'd1;
  localparam logic [2:0] REPEAT_DOUBLE = 3'd4;

  localparam logic [7:0] REG_COL_SHIFT = 8'd0;
  localparam logic [7:0] REG_ROW_SHIFT = 8'd1;

  localparam logic [7:0] COL_SHIFT_RESET = 8'd26;
  localparam logic [7:0] ROW_SHIFT_RESET = 8'd1;

  typedef logic [GLYPH_COLS-1:0][7:0] glyph_t;
  typedef logic [6:0] glyph_index_t;

  typedef struct packed {
    logic [7:0] col_shift;
    logic [7:0] row_shift;
  } cfg_t;

  // Column bytes per glyph, bit n of a byte is row n
  localparam logic [7:0] FONT_ROM [0:GLYPH_COUNT-1][0:GLYPH_COLS-1] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
    '{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
    '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
    '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
    '{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
    '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h3E,8'h41,8'h49,8'h49,8'h7A},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
    '{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
    '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
    '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
    '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
    '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h3F,8'h40,8'h38,8'h40,8'h3F},
    '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7F,8'h41,8'h41,8'h00},
    '{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h41,8'h41,8'h7F,8'h00},
    '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
    '{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
    '{8'h7F,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
    '{8'h38,8'h44,8'h44,8'h48,8'h7F}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
    '{8'h08,8'h7E,8'h09,8'h01,8'h02}, '{8'h0C,8'h52,8'h52,8'h52,8'h3E},
    '{8'h7F,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7D,8'h40,8'h00},
    '{8'h20,8'h40,8'h44,8'h3D,8'h00}, '{8'h7F,8'h10,8'h28,8'h44,8'h00},
    '{8'h00,8'h41,8'h7F,8'h40,8'h00}, '{8'h7C,8'h04,8'h18,8'h04,8'h78},
    '{8'h7C,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
    '{8'h7C,8'h14,8'h14,8'h14,8'h08}, '{8'h08,8'h14,8'h14,8'h18,8'h7C},
    '{8'h7C,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
    '{8'h04,8'h3F,8'h44,8'h40,8'h20}, '{8'h3C,8'h40,8'h40,8'h20,8'h7C},
    '{8'h1C,8'h20,8'h40,8'h20,8'h1C}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C},
    '{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h0C,8'h50,8'h50,8'h50,8'h3C},
    '{8'h44,8'h64,8'h54,8'h4C,8'h44}, '{8'h00,8'h08,8'h36,8'h41,8'h00},
    '{8'h00,8'h00,8'h7F,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00},
    '{8'h10,8'h08,8'h08,8'h10,8'h08}
  };

endpackage

// ===== rtl/gfr_font_rom.sv =====
// ----------------------------------------------------------------------------
// gfr_font_rom
// Synchronous glyph ROM: maps a character byte to its glyph entry and
// registers all five column bytes whenever en is high.
// ----------------------------------------------------------------------------
module gfr_font_rom (
  input  logic           clk,
  input  logic           en,
  input  logic [7:0]     char_code,
  output gfr_pkg::glyph_t glyph
);
  import gfr_pkg::*;

  logic [7:0]   code_eff;
  glyph_index_t idx;

  // Draw anything outside the printable range as '?'
  always_comb begin
    code_eff = char_code;
    if (char_code < CODE_FIRST || char_code > CODE_LAST) begin
      code_eff = CODE_SUBST;
    end
    idx = 7'(code_eff - CODE_FIRST);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        glyph[c] <= FONT_ROM[idx][c];
      end
    end
  end

endmodule

// ===== rtl/gfr_seq.sv =====
// ----------------------------------------------------------------------------
// gfr_seq
// Pixel sequencer: walks the cell row by row (normal) or column by column
// (double size), picks the color from the glyph and registers each word.
// ----------------------------------------------------------------------------
module gfr_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  gfr_pkg::cfg_t   cfg,
  input  gfr_pkg::glyph_t glyph,
  input  logic [7:0]      pos_x,
  input  logic [7:0]      pos_y,
  input  logic [15:0]     fg_color,
  input  logic [15:0]     bg_color,
  input  logic            double_size,
  output logic            strobe,
  output logic [7:0]      win_col_first,
  output logic [7:0]      win_col_final,
  output logic [7:0]      win_row_first,
  output logic [7:0]      win_row_final,
  output logic [15:0]     pixel_color,
  output logic [2:0]      repeat_count,
  output logic            last
);
  import gfr_pkg::*;

  logic        active;
  logic        dbl;
  logic [2:0]  row;
  logic [2:0]  col;
  logic [7:0]  x;
  logic [7:0]  y;
  logic [15:0] fg;
  logic [15:0] bg;

  logic        final_word;
  logic        accept;
  logic [7:0]  col_byte;
  logic        bit_set;
  logic [7:0]  cx;
  logic [7:0]  ry;

  always_comb begin
    if (dbl) begin
      final_word = active && col == COL_LAST_GLYPH && row == ROW_LAST;
    end else begin
      final_word = active && col == COL_LAST_SPACER && row == ROW_LAST;
    end
  end

  // Free up on the last word so the next character follows without a gap
  assign busy   = active && !final_word;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      row    <= '0;
      col    <= '0;
    end else if (accept) begin
      active <= 1'b1;
      row    <= '0;
      col    <= '0;
    end else if (final_word) begin
      active <= 1'b0;
    end else if (active) begin
      if (dbl) begin
        if (row == ROW_LAST) begin
          row <= '0;
          col <= col + 3'd1;
        end else begin
          row <= row + 3'd1;
        end
      end else begin
        if (col == COL_LAST_SPACER) begin
          col <= '0;
          row <= row + 3'd1;
        end else begin
          col <= col + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dbl <= double_size;
      x   <= pos_x;
      y   <= pos_y;
      fg  <= fg_color;
      bg  <= bg_color;
    end
  end

  always_comb begin
    col_byte = '0;
    if (col <= COL_LAST_GLYPH) begin
      col_byte = glyph[col];
    end
    bit_set = col_byte[row];
    cx      = x + 8'({col, 1'b0});
    ry      = y + 8'({row, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      pixel_color <= bit_set ? fg : bg;
      last        <= final_word;
      if (dbl) begin
        win_col_first <= cx + cfg.col_shift;
        win_col_final <= cx + 8'd1 + cfg.col_shift;
        win_row_first <= ry + cfg.row_shift;
        win_row_final <= ry + 8'd1 + cfg.row_shift;
        repeat_count  <= REPEAT_DOUBLE;
      end else begin
        win_col_first <= x + cfg.col_shift;
        win_col_final <= x + 8'd5 + cfg.col_shift;
        win_row_first <= y + cfg.row_shift;
        win_row_final <= y + 8'd6 + cfg.row_shift;
        repeat_count  <= REPEAT_NORMAL;
      end
    end
  end

endmodule

// ===== rtl/glyph_5x7_pixel_rasterizer.sv =====
// ----------------------------------------------------------------------------
// glyph_5x7_pixel_rasterizer
// Once a start is taken, the sequencer goes active and the ROM registers the
// glyph; each pixel word is then registered with its strobe, one a cycle,
// 42 for a normal cell and 35 for a double one. The next character is taken
// while the last word is formed, so back-to-back characters leave no gap.
// Reset clears the sequencer and sets the offsets to 26 and 1; the receiver
// cannot stall, each word is valid for its single strobe cycle.
// ----------------------------------------------------------------------------
module glyph_5x7_pixel_rasterizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [7:0]  char_code,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  input  logic [15:0] fg_color,
  input  logic [15:0] bg_color,
  input  logic        double_size,
  output logic        strobe,
  output logic [7:0]  win_col_first,
  output logic [7:0]  win_col_final,
  output logic [7:0]  win_row_first,
  output logic [7:0]  win_row_final,
  output logic [15:0] pixel_color,
  output logic [2:0]  repeat_count,
  output logic        last
);
  import gfr_pkg::*;

  cfg_t   cfg;
  glyph_t glyph;
  logic   accept;

  assign accept = start && !busy;

  // Unknown register indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.col_shift <= COL_SHIFT_RESET;
      cfg.row_shift <= ROW_SHIFT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_COL_SHIFT) begin
        cfg.col_shift <= cfg_data;
      end else if (cfg_index == REG_ROW_SHIFT) begin
        cfg.row_shift <= cfg_data;
      end
    end
  end

  gfr_font_rom u_rom (
    .clk       (clk),
    .en        (accept),
    .char_code (char_code),
    .glyph     (glyph)
  );

  gfr_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cfg           (cfg),
    .glyph         (glyph),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .fg_color      (fg_color),
    .bg_color      (bg_color),
    .double_size   (double_size),
    .strobe        (strobe),
    .win_col_first (win_col_first),
    .win_col_final (win_col_final),
    .win_row_first (win_row_first),
    .win_row_final (win_row_final),
    .pixel_color   (pixel_color),
    .repeat_count  (repeat_count),
    .last          (last)
  );

endmodule
